>>> rtl/wsfp_pkg.sv
// Shared types and constants for the WebSocket frame parser with unmasking.
// No dependencies; imported by wsfp_parser and websocket_frame_parser_unmask.
`timescale 1ns / 1ps

package wsfp_pkg;

    localparam logic [3:0]  CLOSE_OPCODE  = 4'h8;
    localparam logic [6:0]  LEN16_CODE    = 7'd126;
    localparam logic [6:0]  LEN64_CODE    = 7'd127;
    localparam logic [31:0] MAX_LEN_RESET = 32'(10 * 1024 * 1024);

    typedef enum logic [2:0] {
        ST_HDR1   = 3'd0,
        ST_HDR2   = 3'd1,
        ST_EXTLEN = 3'd2,
        ST_KEY    = 3'd3,
        ST_DATA   = 3'd4,
        ST_CLOSED = 3'd5,
        ST_ERROR  = 3'd6
    } t_state;

    typedef enum logic [2:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_EMPTY    = 3'd1,
        KIND_CLOSE    = 3'd2,
        KIND_BADFRAME = 3'd3,
        KIND_BADLEN   = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [3:0] opcode;
        logic       fin;
        logic       last;
    } t_result;

endpackage

>>> rtl/wsfp_parser.sv
// Header parse state machine and payload unmasking, one byte per transfer.
// Depends on wsfp_pkg; the result is combinational, registered by the top level.
`timescale 1ns / 1ps

module wsfp_parser
    import wsfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_byte_valid,
    input  logic [7:0]  i_byte,
    input  logic [31:0] i_max_len,
    output logic        o_res_valid,
    output t_result     o_res
);

    t_state      r_state,  n_state;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_fin,    n_fin;
    logic        r_mask,   n_mask;
    logic [6:0]  r_lcode,  n_lcode;
    logic [63:0] r_acc,    n_acc;
    logic [2:0]  r_cnt,    n_cnt;
    logic [31:0] r_key,    n_key;
    logic [31:0] r_plen,   n_plen;
    logic [31:0] r_pcnt,   n_pcnt;

    logic [63:0] w_acc_next;
    logic [2:0]  w_cnt_next;
    logic [31:0] w_pcnt_next;
    logic        w_bad64;
    logic [7:0]  w_key_byte;

    assign w_acc_next  = {r_acc[55:0], i_byte};
    assign w_cnt_next  = r_cnt + 3'd1;
    assign w_pcnt_next = r_pcnt + 32'd1;
    assign w_bad64     = w_acc_next[63] || (w_acc_next[62:32] != 31'd0)
                         || (w_acc_next[31:0] > i_max_len);

    // next state and register updates
    always_comb begin
        n_state  = r_state;
        n_opcode = r_opcode;
        n_fin    = r_fin;
        n_mask   = r_mask;
        n_lcode  = r_lcode;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_key    = r_key;
        n_plen   = r_plen;
        n_pcnt   = r_pcnt;
        if (i_byte_valid) begin
            unique case (r_state)
                ST_HDR1: begin
                    n_fin    = i_byte[7];
                    n_opcode = i_byte[3:0];
                    n_state  = (i_byte[6:4] != 3'd0) ? ST_ERROR : ST_HDR2;
                end
                ST_HDR2: begin
                    n_mask  = i_byte[7];
                    n_lcode = i_byte[6:0];
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_key   = '0;
                    if (i_byte[6:0] == LEN16_CODE || i_byte[6:0] == LEN64_CODE) begin
                        n_state = ST_EXTLEN;
                    end else begin
                        n_plen  = {25'd0, i_byte[6:0]};
                        n_state = ST_HDR1;
                    end
                end
                ST_EXTLEN: begin
                    n_acc = w_acc_next;
                    n_cnt = w_cnt_next;
                    if (r_lcode == LEN16_CODE) begin
                        if (w_cnt_next >= 3'd2) begin
                            if (w_acc_next < 64'(LEN16_CODE)) begin
                                n_state = ST_ERROR;
                            end else begin
                                n_plen  = {16'd0, w_acc_next[15:0]};
                                n_state = ST_HDR1;
                            end
                        end
                    end else if (w_cnt_next == 3'd0) begin
                        if (w_bad64) begin
                            n_state = ST_ERROR;
                        end else begin
                            n_plen  = w_acc_next[31:0];
                            n_state = ST_HDR1;
                        end
                    end
                end
                ST_KEY: begin
                    n_key = {r_key[23:0], i_byte};
                    n_cnt = w_cnt_next;
                    if (w_cnt_next >= 3'd4) begin
                        n_state = ST_HDR1;
                    end
                end
                ST_DATA: begin
                    n_pcnt = w_pcnt_next;
                    if (w_pcnt_next >= r_plen) begin
                        n_state = ST_HDR1;
                    end
                end
                default: begin
                    n_state = r_state;
                end
            endcase

            // length complete: go on to the key, or finish the header
            if ((r_state == ST_HDR2 || r_state == ST_EXTLEN) && n_state == ST_HDR1) begin
                n_cnt = '0;
                if (n_mask) begin
                    n_state = ST_KEY;
                end
            end
            if ((r_state == ST_HDR2 || r_state == ST_EXTLEN || r_state == ST_KEY)
                && n_state == ST_HDR1) begin
                n_cnt = '0;
                if (r_opcode == CLOSE_OPCODE) begin
                    n_state = ST_CLOSED;
                end else if (n_plen != 32'd0) begin
                    n_pcnt  = '0;
                    n_state = ST_DATA;
                end
            end
        end
    end

    always_comb begin
        unique case (r_pcnt[1:0])
            2'd0: w_key_byte = r_key[31:24];
            2'd1: w_key_byte = r_key[23:16];
            2'd2: w_key_byte = r_key[15:8];
            2'd3: w_key_byte = r_key[7:0];
        endcase
    end

    // result, derived from the transition taken
    always_comb begin
        o_res_valid   = 1'b0;
        o_res.kind    = KIND_BADFRAME;
        o_res.data    = 8'd0;
        o_res.opcode  = n_opcode;
        o_res.fin     = n_fin;
        o_res.last    = 1'b0;
        if (i_byte_valid) begin
            unique case (r_state)
                ST_HDR1: begin
                    o_res_valid = (n_state == ST_ERROR);
                end
                ST_HDR2, ST_EXTLEN, ST_KEY: begin
                    if (n_state == ST_ERROR) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_BADLEN;
                    end else if (n_state == ST_CLOSED) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_CLOSE;
                    end else if (n_state == ST_HDR1) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_EMPTY;
                        o_res.last  = 1'b1;
                    end
                end
                ST_DATA: begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_PAYLOAD;
                    o_res.data  = r_mask ? (i_byte ^ w_key_byte) : i_byte;
                    o_res.last  = (n_state == ST_HDR1);
                end
                default: begin
                    o_res_valid = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_HDR1;
            r_opcode <= '0;
            r_fin    <= 1'b0;
            r_mask   <= 1'b0;
            r_lcode  <= '0;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_key    <= '0;
            r_plen   <= '0;
            r_pcnt   <= '0;
        end else begin
            r_state  <= n_state;
            r_opcode <= n_opcode;
            r_fin    <= n_fin;
            r_mask   <= n_mask;
            r_lcode  <= n_lcode;
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            r_key    <= n_key;
            r_plen   <= n_plen;
            r_pcnt   <= n_pcnt;
        end
    end

endmodule

>>> rtl/websocket_frame_parser_unmask.sv
// Top level of the WebSocket frame parser: config register, parser, output skid.
// Depends on wsfp_pkg and wsfp_parser.
`timescale 1ns / 1ps

// Usage
//   Slave stream carries the frame byte stream, one byte per transfer in tdata.
//   Master stream gives at most one result per input byte: tuser holds the
//   result kind, tdata the unmasked payload byte, opcode and FIN, tlast marks
//   the final payload byte of a frame or an empty frame. Header bytes that do
//   not finish a header give nothing, unless they are found bad.
//   The config channel writes the maximum length for 64-bit coded frames;
//   write it only while the block is idle. It is always ready.
// Output path and throughput
//   A result is registered in the output register, or in the skid register
//   when the output is held; one byte is taken every cycle while skid is empty.
// Reset
//   Synchronous, active low: parser back to the first header byte, maximum
//   length back to 10 MiB, output stage empty.
// Stall
//   While the receiver holds tready low, one further result is kept in a skid
//   register; then s_axis_tready drops until the output result is taken.
//   After a close or an error every byte gives an invalid-frame result.

module websocket_frame_parser_unmask
    import wsfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] payload_byte, [11:8] frame_opcode,
                                          // [12] frame_fin, [15:13] zero
    output logic [2:0]  o_m_axis_tuser,   // [2:0] result_kind
    output logic        o_m_axis_tlast,   // last_of_frame
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data        // max_payload_length
);

    logic [31:0] r_max_len;
    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    logic        w_accept;
    logic        w_pop;
    logic        w_res_valid;
    t_result     w_res;

    assign o_cfg_ready     = 1'b1;
    // only the skid slot limits intake
    assign o_s_axis_tready = !r_skid_valid;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_pop           = r_out_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_len <= i_cfg_data;
        end
    end

    wsfp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (w_accept),
        .i_byte       (i_s_axis_tdata),
        .i_max_len    (r_max_len),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res)
    );

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_res_valid;
            end
        end else if (w_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // payload: advance from skid first, else take the fresh result
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_res_valid) begin
            r_skid <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'd0, r_out.fin, r_out.opcode, r_out.data};
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last;

endmodule
